// ===== sv/key_matrix_scan_ghost_report_macros.svh =====
// assertion macros used by the scan sequencer (kmsg_seq)
`ifndef KEY_MATRIX_SCAN_GHOST_REPORT_MACROS_SVH
`define KEY_MATRIX_SCAN_GHOST_REPORT_MACROS_SVH
`ifndef SYNTHESIS
`define KMSG_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);
`define KMSG_NEVER(lbl, cond, msg) `KMSG_ASSERT(lbl, !(cond), msg)
`else
`define KMSG_ASSERT(lbl, prop, msg)
`define KMSG_NEVER(lbl, cond, msg)
`endif
`endif

// ===== sv/kmsg_pkg.sv =====
package kmsg_pkg;

    // commands carried in tuser
    localparam logic [1:0] CMD_SCAN   = 2'd0;
    localparam logic [1:0] CMD_KEYMAP = 2'd1;
    localparam logic [1:0] CMD_FNTAB  = 2'd2;

    // usage ranges
    localparam logic [7:0] MOD_LO  = 8'hE0;
    localparam logic [7:0] MOD_HI  = 8'hE7;
    localparam logic [7:0] FKEY_LO = 8'h3A;
    localparam logic [7:0] FKEY_HI = 8'h45;
    localparam logic [7:0] MOD_BIT_MASK = 8'h07;

    localparam int SLOTS     = 6;
    localparam int SCAN_BITS = 16;
    localparam int FN_W      = 25;
    localparam int IN_W      = 64;
    localparam int OUT_W     = 88;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_SCAN,
        ST_TAIL,
        ST_FIN
    } t_state;

    // sequencer to frame builder
    typedef struct packed {
        logic                 start_clear;
        logic                 key_en;
        logic                 held;
        logic                 fin;
        logic                 last_col;
        logic                 host_ready;
        logic [SCAN_BITS-1:0] cur;
    } t_frame_ctrl;

endpackage

// ===== sv/key_matrix_scan_ghost_report.sv =====
// channel   dir  bits  contents
// s_*       in   64+2  scan column or table entry request
// m_*       out  88    frame report at the last column
// cfg       in   1     fn_lock write
//
// a column scan reads the keymap and function table once per row for min(ROWS,16)
// rows through the single read port of each memory, then takes a ghost step
// a table write is done when its request is accepted; other requests are dropped
// after reset all COLS*ROWS entries of both tables are cleared with s_tready low
// a report waits in the output register; a new scan may run meanwhile and
// only its end of frame stalls until the report is taken

module key_matrix_scan_ghost_report import kmsg_pkg::*; #(
    parameter int COLS     = 8,
    parameter int ROWS     = 16,
    parameter int MAX_KEYS = 6
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             s_tvalid,
    output logic             s_tready,
    // col, row_bits, row, key_code, fn_valid, consumer_code, fn_code,
    // fn_held, host_ready, zero fill
    input  logic [IN_W-1:0]  s_tdata,
    // cmd
    input  logic [1:0]       s_tuser,
    output logic             m_tvalid,
    input  logic             m_tready,
    // modifiers, key0..key5, consumer_out, function_out, send_keyboard,
    // send_consumer, function_changed, zero fill
    output logic [OUT_W-1:0] m_tdata,
    input  logic             i_cfg_wen,
    input  logic             i_cfg_wdata
);

    localparam int DEPTH = COLS * ROWS;
    localparam int AW    = $clog2(DEPTH);

    logic            km_we, fn_we, out_free;
    logic [AW-1:0]   waddr, raddr;
    logic [7:0]      km_wdata, km_rdata;
    logic [FN_W-1:0] fn_wdata, fn_rdata;
    t_frame_ctrl     ctrl;

    kmsg_seq #(.COLS(COLS), .ROWS(ROWS)) u_seq (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(s_tvalid), .i_cmd(s_tuser),
        .i_data(s_tdata), .i_out_free(out_free), .o_ready(s_tready),
        .o_km_we(km_we), .o_fn_we(fn_we), .o_waddr(waddr), .o_km_wdata(km_wdata),
        .o_fn_wdata(fn_wdata), .o_raddr(raddr), .o_ctrl(ctrl)
    );

    kmsg_ram #(.W(8), .D(DEPTH)) u_keymap (
        .i_clk(i_clk), .i_we(km_we), .i_waddr(waddr), .i_wdata(km_wdata),
        .i_raddr(raddr), .o_rdata(km_rdata)
    );

    kmsg_ram #(.W(FN_W), .D(DEPTH)) u_fntab (
        .i_clk(i_clk), .i_we(fn_we), .i_waddr(waddr), .i_wdata(fn_wdata),
        .i_raddr(raddr), .o_rdata(fn_rdata)
    );

    kmsg_frame #(.MAX_KEYS(MAX_KEYS)) u_frame (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_ctrl(ctrl), .i_usage(km_rdata),
        .i_fent(fn_rdata), .i_cfg_wen(i_cfg_wen), .i_cfg_wdata(i_cfg_wdata),
        .i_m_ready(m_tready), .o_m_valid(m_tvalid), .o_m_data(m_tdata),
        .o_out_free(out_free)
    );

endmodule

// ===== sv/kmsg_ram.sv =====
module kmsg_ram #(
    parameter int W = 8,
    parameter int D = 128
) (
    input  logic                 i_clk,
    input  logic                 i_we,
    input  logic [$clog2(D)-1:0] i_waddr,
    input  logic [W-1:0]         i_wdata,
    input  logic [$clog2(D)-1:0] i_raddr,
    output logic [W-1:0]         o_rdata
);

    logic [W-1:0] r_mem [D];
    logic [W-1:0] r_rdata;

    // one write port, registered read
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== sv/kmsg_seq.sv =====
`include "key_matrix_scan_ghost_report_macros.svh"

module kmsg_seq import kmsg_pkg::*; #(
    parameter int COLS = 8,
    parameter int ROWS = 16
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_valid,
    input  logic [1:0]                       i_cmd,
    input  logic [IN_W-1:0]                  i_data,
    input  logic                             i_out_free,
    output logic                             o_ready,
    output logic                             o_km_we,
    output logic                             o_fn_we,
    output logic [$clog2(COLS*ROWS)-1:0]     o_waddr,
    output logic [7:0]                       o_km_wdata,
    output logic [FN_W-1:0]                  o_fn_wdata,
    output logic [$clog2(COLS*ROWS)-1:0]     o_raddr,
    output t_frame_ctrl                      o_ctrl
);

    localparam int DEPTH = COLS * ROWS;
    localparam int AW    = $clog2(DEPTH);
    localparam int NR    = (ROWS < SCAN_BITS) ? ROWS : SCAN_BITS;
    localparam int RCW   = $clog2(NR);
    localparam logic [SCAN_BITS-1:0] ROW_MASK = SCAN_BITS'((33'd1 << NR) - 33'd1);

    t_state         r_state, n_state;
    logic [AW-1:0]  r_clr;
    logic [2:0]     r_col;
    logic [15:0]    r_bits;
    logic           r_held;
    logic           r_host;
    logic [RCW-1:0] r_rc;
    logic           r_pend;
    logic [RCW-1:0] r_prow;

    // input field decode
    logic [2:0]  f_col;
    logic [15:0] f_bits;
    logic [3:0]  f_row;
    logic        accept, col_ok, row_ok, is_scan, last_col, fin_go;

    assign f_col  = i_data[2:0];
    assign f_bits = i_data[18:3];
    assign f_row  = i_data[22:19];
    assign accept = i_valid && o_ready;
    assign col_ok = int'(f_col) < COLS;
    assign row_ok = int'(f_row) < ROWS;
    assign is_scan = col_ok && (i_cmd == CMD_SCAN);
    assign last_col = int'(r_col) == COLS - 1;
    assign fin_go = (r_state == ST_FIN) && (!last_col || i_out_free);

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_CLEAR: if (r_clr == AW'(DEPTH - 1)) n_state = ST_IDLE;
            ST_IDLE:  if (accept && is_scan) n_state = ST_SCAN;
            ST_SCAN:  if (r_rc == RCW'(NR - 1)) n_state = ST_TAIL;
            ST_TAIL:  n_state = ST_FIN;
            ST_FIN:   if (fin_go) n_state = ST_IDLE;
            default:  n_state = ST_CLEAR;
        endcase
    end

    // outputs: handshake, memory ports, frame control
    always_comb begin
        o_ready    = (r_state == ST_IDLE);
        o_km_we    = 1'b0;
        o_fn_we    = 1'b0;
        o_waddr    = AW'(int'(f_col) * ROWS + int'(f_row));
        o_km_wdata = i_data[30:23];
        o_fn_wdata = {i_data[31], i_data[47:32], i_data[55:48]};
        o_raddr    = AW'(int'(r_col) * ROWS + int'(r_rc));
        case (r_state)
            ST_CLEAR: begin
                o_km_we    = 1'b1;
                o_fn_we    = 1'b1;
                o_waddr    = r_clr;
                o_km_wdata = '0;
                o_fn_wdata = '0;
            end
            ST_IDLE: begin
                o_km_we = accept && col_ok && row_ok && (i_cmd == CMD_KEYMAP);
                o_fn_we = accept && col_ok && row_ok && (i_cmd == CMD_FNTAB);
            end
            default: ;
        endcase
        o_ctrl.start_clear = accept && is_scan && (f_col == 3'd0);
        o_ctrl.key_en      = r_pend && r_bits[4'(r_prow)];
        o_ctrl.held        = r_held;
        o_ctrl.fin         = fin_go;
        o_ctrl.last_col    = last_col;
        o_ctrl.host_ready  = r_host;
        o_ctrl.cur         = r_bits & ROW_MASK;
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_CLEAR;
            r_clr   <= '0;
            r_rc    <= '0;
            r_pend  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_pend  <= (r_state == ST_SCAN);
            if (r_state == ST_CLEAR) r_clr <= r_clr + AW'(1);
            if (r_state == ST_SCAN) r_rc <= r_rc + RCW'(1);
            else r_rc <= '0;
        end
    end

    // latched scan item
    always_ff @(posedge i_clk) begin
        r_prow <= r_rc;
        if (accept && is_scan) begin
            r_col  <= f_col;
            r_bits <= f_bits;
            r_held <= i_data[56];
            r_host <= i_data[57];
        end
    end

    `KMSG_ASSERT(a_clear_blocks, (r_state == ST_CLEAR) |-> !o_ready, "ready during clear")
    `KMSG_NEVER(a_scan_no_write, (r_state == ST_SCAN || r_state == ST_TAIL) && (o_km_we || o_fn_we), "table write during scan")
    `KMSG_ASSERT(a_scan_starts, (accept && is_scan) |=> (r_state == ST_SCAN), "scan request did not start walk")

endmodule

// ===== sv/kmsg_frame.sv =====
module kmsg_frame import kmsg_pkg::*; #(
    parameter int MAX_KEYS = 6
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  t_frame_ctrl      i_ctrl,
    input  logic [7:0]       i_usage,
    input  logic [FN_W-1:0]  i_fent,
    input  logic             i_cfg_wen,
    input  logic             i_cfg_wdata,
    input  logic             i_m_ready,
    output logic             o_m_valid,
    output logic [OUT_W-1:0] o_m_data,
    output logic             o_out_free
);

    logic                        r_fn_lock;
    logic [7:0]                  r_mod, n_mod, r_last_mod, n_last_mod;
    logic [SLOTS-1:0][7:0]       r_slot, n_slot, r_last_slot, n_last_slot;
    logic [2:0]                  r_cnt, n_cnt;
    logic                        r_pressed, n_pressed, r_last_pressed, n_last_pressed;
    logic [15:0]                 r_hot, n_hot, r_last_hot, n_last_hot;
    logic [7:0]                  r_func, n_func, r_last_func, n_last_func;
    logic [SCAN_BITS-1:0]        r_seen, n_seen;
    logic                        r_ghost, n_ghost;
    logic                        r_m_valid, n_m_valid;
    logic [OUT_W-1:0]            r_m_data, n_m_data;

    logic                 fe_valid, fkey, is_mod, room;
    logic [15:0]          fe_cons;
    logic [7:0]           fe_code;
    logic [SCAN_BITS-1:0] again;
    logic                 skb, scons, fchg;

    assign fe_valid = i_fent[24];
    assign fe_cons  = i_fent[23:8];
    assign fe_code  = i_fent[7:0];
    assign fkey     = (i_usage >= FKEY_LO) && (i_usage <= FKEY_HI);
    assign is_mod   = (i_usage >= MOD_LO) && (i_usage <= MOD_HI);
    assign room     = int'(r_cnt) < MAX_KEYS;
    assign again    = i_ctrl.cur & r_seen;

    // key rules, ghost check and end of frame
    always_comb begin
        n_mod = r_mod;  n_slot = r_slot;  n_cnt = r_cnt;  n_pressed = r_pressed;
        n_hot = r_hot;  n_func = r_func;  n_seen = r_seen;  n_ghost = r_ghost;
        n_last_mod = r_last_mod;  n_last_slot = r_last_slot;
        n_last_hot = r_last_hot;  n_last_func = r_last_func;
        n_last_pressed = r_last_pressed;
        n_m_valid = r_m_valid && !i_m_ready;
        n_m_data  = r_m_data;
        skb = 1'b0;  scons = 1'b0;  fchg = 1'b0;

        // frame start
        if (i_ctrl.start_clear) begin
            n_mod = '0;  n_slot = '0;  n_cnt = '0;  n_pressed = 1'b0;
            n_hot = '0;  n_func = '0;  n_seen = '0;  n_ghost = 1'b0;
        end

        // one pressed key
        if (i_ctrl.key_en && (i_usage != 8'd0)) begin
            if (!i_ctrl.held) begin
                if (is_mod) begin
                    n_mod = r_mod | (8'd1 << (i_usage & MOD_BIT_MASK));
                end else if (r_fn_lock && fkey) begin
                    if (fe_valid) begin
                        n_pressed = 1'b1;
                        n_hot = fe_cons;
                        n_func = fe_code;
                        n_mod = '0;
                        n_slot = '0;
                    end
                end else if (room) begin
                    for (int i = 0; i < SLOTS; i++) begin
                        if (3'(i) == r_cnt) n_slot[i] = i_usage;
                    end
                    n_cnt = r_cnt + 3'd1;
                    n_pressed = 1'b1;
                    n_hot = '0;
                end
            end else begin
                if (r_fn_lock && fkey) begin
                    if (!r_pressed) begin
                        n_slot[0] = i_usage;
                        n_pressed = 1'b1;
                        n_hot = '0;
                    end
                end else if (fe_valid && room) begin
                    for (int i = 0; i < SLOTS; i++) begin
                        if (3'(i) == r_cnt) n_slot[i] = fe_code;
                    end
                    n_cnt = r_cnt + 3'd1;
                    n_pressed = 1'b1;
                    n_hot = '0;
                end
            end
        end

        // column done: ghost check, report at last column
        if (i_ctrl.fin) begin
            n_ghost = r_ghost || ((again & (again - SCAN_BITS'(1))) != '0);
            n_seen  = r_seen | i_ctrl.cur;
            if (i_ctrl.last_col) begin
                if (!n_ghost) begin
                    n_last_mod = r_mod;  n_last_slot = r_slot;  n_last_hot = r_hot;
                    n_last_func = r_func;  n_last_pressed = r_pressed;
                end
                skb   = ((n_last_mod != r_last_mod) || (n_last_slot != r_last_slot))
                        && i_ctrl.host_ready;
                scons = (n_last_hot != r_last_hot) && i_ctrl.host_ready;
                fchg  = n_last_func != r_last_func;
                n_m_valid = 1'b1;
                n_m_data  = {5'd0, fchg, scons, skb, n_last_func, n_last_hot,
                             n_last_slot, n_last_mod};
                n_mod = '0;  n_slot = '0;  n_cnt = '0;  n_pressed = 1'b0;
                n_hot = '0;  n_func = '0;  n_seen = '0;  n_ghost = 1'b0;
            end
        end
    end

    // frame state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fn_lock <= 1'b0;
            r_mod <= '0;  r_slot <= '0;  r_cnt <= '0;  r_pressed <= 1'b0;
            r_hot <= '0;  r_func <= '0;  r_seen <= '0;  r_ghost <= 1'b0;
            r_last_mod <= '0;  r_last_slot <= '0;  r_last_hot <= '0;
            r_last_func <= '0;  r_last_pressed <= 1'b0;
            r_m_valid <= 1'b0;
        end else begin
            if (i_cfg_wen) r_fn_lock <= i_cfg_wdata;
            r_mod <= n_mod;  r_slot <= n_slot;  r_cnt <= n_cnt;  r_pressed <= n_pressed;
            r_hot <= n_hot;  r_func <= n_func;  r_seen <= n_seen;  r_ghost <= n_ghost;
            r_last_mod <= n_last_mod;  r_last_slot <= n_last_slot;
            r_last_hot <= n_last_hot;  r_last_func <= n_last_func;
            r_last_pressed <= n_last_pressed;
            r_m_valid <= n_m_valid;
        end
    end

    // result payload
    always_ff @(posedge i_clk) begin
        r_m_data <= n_m_data;
    end

    assign o_m_valid  = r_m_valid;
    assign o_m_data   = r_m_data;
    assign o_out_free = !r_m_valid || i_m_ready;

endmodule
